// File: hw/rtl/jsu_pkg.sv
// Package for the JSON string unescaper: mode codes, state and result-burst
// types, character constants and the UTF-8 / hex helper functions.
// No dependencies.
`default_nettype none

package jsu_pkg;

	// Most results one input byte can cause (three bytes of U+FFFD plus the end mark,
	// or four UTF-8 bytes)
	localparam int BURST_MAX = 4;
	localparam int CNT_W     = $clog2(BURST_MAX + 1);

	// Characters the decoder looks at
	localparam logic [7:0] CHAR_QUOTE  = 8'h22;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_U      = 8'h75;
	localparam logic [7:0] CHAR_N      = 8'h6E;
	localparam logic [7:0] CHAR_R      = 8'h72;
	localparam logic [7:0] CHAR_T      = 8'h74;
	localparam logic [7:0] CHAR_F      = 8'h66;
	localparam logic [7:0] CHAR_A      = 8'h61;

	// Control codes the short escapes stand for
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_FF  = 8'h0C;
	localparam logic [7:0] CODE_BEL = 8'h07;

	// UTF-16 surrogate range and the replacement character
	localparam logic [15:0] SURR_FIRST = 16'hD800;
	localparam logic [15:0] SURR_TRAIL = 16'hDC00;
	localparam logic [15:0] SURR_LAST  = 16'hDFFF;
	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
	localparam logic [20:0] CP_PLANE1  = 21'h010000;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_HEX1  = 3'd2,
		MODE_HEX2  = 3'd3,
		MODE_HEX3  = 3'd4,
		MODE_HEX4  = 3'd5
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] accum;
		logic [15:0] held;
		logic        held_valid;
	} state_t;

	// One result beat
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data;
		logic       string_end;
		logic       bad_escape;
	} entry_t;

	// Results of one input byte, entry 0 goes out first
	typedef struct packed {
		entry_t [BURST_MAX-1:0] ent;
		logic   [CNT_W-1:0]     cnt;
	} burst_t;

	function automatic entry_t mk_byte(input logic [7:0] b);
		entry_t e;
		e            = '0;
		e.has_byte   = 1'b1;
		e.data       = b;
		return e;
	endfunction

	// Encode a code point as one to four UTF-8 bytes
	function automatic burst_t utf8_encode(input logic [20:0] cp);
		burst_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.ent[0] = mk_byte(cp[7:0]);
			r.cnt    = CNT_W'(1);
		end else if (cp < 21'h800) begin
			r.ent[0] = mk_byte({3'b110, cp[10:6]});
			r.ent[1] = mk_byte({2'b10, cp[5:0]});
			r.cnt    = CNT_W'(2);
		end else if (cp < 21'h10000) begin
			r.ent[0] = mk_byte({4'b1110, cp[15:12]});
			r.ent[1] = mk_byte({2'b10, cp[11:6]});
			r.ent[2] = mk_byte({2'b10, cp[5:0]});
			r.cnt    = CNT_W'(3);
		end else begin
			r.ent[0] = mk_byte({5'b11110, cp[20:18]});
			r.ent[1] = mk_byte({2'b10, cp[17:12]});
			r.ent[2] = mk_byte({2'b10, cp[11:6]});
			r.ent[3] = mk_byte({2'b10, cp[5:0]});
			r.cnt    = CNT_W'(4);
		end
		return r;
	endfunction

	// Hex digit value, bit 4 set when the character is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/json_string_unescape_core.sv
// JSON string unescaper, top level: input register, decode, result burst register.
// Depends on jsu_pkg and jsu_decode.
//
// Feed the bytes of a JSON string body after its opening quote; each out beat carries
// one decoded byte, or the end-of-string or bad-escape mark, with run_last on the final
// beat of each input byte. Bytes that cause at most one result stream at one byte per
// cycle while out_stall is low. A byte that causes several results (UTF-8 of an escaped
// code point, up to four beats) holds the result register until its last beat is taken,
// during which one more input byte is absorbed by the input register before in_stall
// rises. The closing quote and a bad hex digit both return the decode state to reset.
`default_nettype none

module json_string_unescape_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output var  logic       in_stall,
	input  wire logic [7:0] in_byte,
	output var  logic       out_valid,
	input  wire logic       out_stall,
	output var  logic       has_byte,
	output var  logic [7:0] out_byte,
	output var  logic       run_last,
	output var  logic       string_end,
	output var  logic       bad_escape
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	jsu_pkg::burst_t  burst_s2;
	jsu_pkg::burst_t  burst_next;
	jsu_pkg::burst_t  burst_shift;
	jsu_pkg::state_t  state_q;
	jsu_pkg::state_t  state_next;
	logic             out_take;
	logic             burst_free;
	logic             s1_move;
	logic             in_take;

	jsu_decode u_decode (
		.cur (state_q),
		.c   (byte_s1),
		.nxt (state_next),
		.res (burst_next)
	);

	// Handshake between the stages
	assign out_valid  = (burst_s2.cnt != '0);
	assign out_take   = out_valid && !out_stall;
	assign burst_free = (burst_s2.cnt == '0) ||
	                    ((burst_s2.cnt == jsu_pkg::CNT_W'(1)) && out_take);
	assign s1_move    = valid_s1 && burst_free;
	assign in_stall   = valid_s1 && !burst_free;
	assign in_take    = in_valid && !in_stall;

	// Present the head of the burst
	assign has_byte   = burst_s2.ent[0].has_byte;
	assign out_byte   = burst_s2.ent[0].data;
	assign string_end = burst_s2.ent[0].string_end;
	assign bad_escape = burst_s2.ent[0].bad_escape;
	assign run_last   = (burst_s2.cnt == jsu_pkg::CNT_W'(1));

	// Advance the burst by one beat
	always_comb begin
		burst_shift     = burst_s2;
		burst_shift.cnt = burst_s2.cnt - jsu_pkg::CNT_W'(1);
		for (int i = 0; i < jsu_pkg::BURST_MAX; i++) begin
			if (i < jsu_pkg::BURST_MAX - 1) begin
				burst_shift.ent[i] = burst_s2.ent[i+1];
			end else begin
				burst_shift.ent[i] = '0;
			end
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	// Load a new burst or drop the beat just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_s2 <= '0;
		end else if (s1_move) begin
			burst_s2 <= burst_next;
		end else if (out_take) begin
			burst_s2 <= burst_shift;
		end
	end

	// Update escape and surrogate state as each byte is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_move) begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/jsu_decode.sv
// Combinational decode of one string byte against the current escape state:
// gives the next state and the burst of results the byte causes.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
	input  var jsu_pkg::state_t cur,
	input  wire logic [7:0]     c,
	output var jsu_pkg::state_t nxt,
	output var jsu_pkg::burst_t res
);

	logic [4:0]  hex;
	logic [15:0] acc;
	logic        is_hex_mode;
	logic        new_first;
	logic        held_first;
	logic [15:0] hi_half;
	logic [15:0] lo_half;

	assign hex         = jsu_pkg::hex_digit(c);
	assign acc         = {cur.accum[11:0], hex[3:0]};
	assign is_hex_mode = (cur.mode == jsu_pkg::MODE_HEX1) || (cur.mode == jsu_pkg::MODE_HEX2) ||
	                     (cur.mode == jsu_pkg::MODE_HEX3) || (cur.mode == jsu_pkg::MODE_HEX4);
	assign new_first   = acc < jsu_pkg::SURR_TRAIL;
	assign held_first  = cur.held < jsu_pkg::SURR_TRAIL;
	assign hi_half     = new_first ? acc : cur.held;
	assign lo_half     = new_first ? cur.held : acc;

	// Decode the byte
	always_comb begin
		nxt = cur;
		res = '0;
		if (cur.mode == jsu_pkg::MODE_ESC) begin
			nxt.mode = jsu_pkg::MODE_PLAIN;
			res.cnt  = jsu_pkg::CNT_W'(1);
			case (c)
				jsu_pkg::CHAR_N: res.ent[0] = jsu_pkg::mk_byte(jsu_pkg::CODE_LF);
				jsu_pkg::CHAR_R: res.ent[0] = jsu_pkg::mk_byte(jsu_pkg::CODE_CR);
				jsu_pkg::CHAR_T: res.ent[0] = jsu_pkg::mk_byte(jsu_pkg::CODE_TAB);
				jsu_pkg::CHAR_F: res.ent[0] = jsu_pkg::mk_byte(jsu_pkg::CODE_FF);
				jsu_pkg::CHAR_A: res.ent[0] = jsu_pkg::mk_byte(jsu_pkg::CODE_BEL);
				jsu_pkg::CHAR_U: begin
					nxt.mode  = jsu_pkg::MODE_HEX1;
					nxt.accum = '0;
					res.cnt   = '0;
				end
				default: res.ent[0] = jsu_pkg::mk_byte(c);
			endcase
		end else if (c == jsu_pkg::CHAR_QUOTE) begin
			// Close the string: flush an unpaired surrogate, mark the end, reset
			nxt = '0;
			if (cur.held_valid) begin
				res                   = jsu_pkg::utf8_encode(jsu_pkg::CP_REPLACE);
				res.ent[3]            = '0;
				res.ent[3].string_end = 1'b1;
				res.cnt               = jsu_pkg::CNT_W'(4);
			end else begin
				res.ent[0].string_end = 1'b1;
				res.cnt               = jsu_pkg::CNT_W'(1);
			end
		end else if (is_hex_mode) begin
			if (!hex[4]) begin
				// Abandon the string on a bad digit
				nxt                   = '0;
				res.ent[0].bad_escape = 1'b1;
				res.cnt               = jsu_pkg::CNT_W'(1);
			end else begin
				case (cur.mode)
					jsu_pkg::MODE_HEX1: begin
						nxt.mode  = jsu_pkg::MODE_HEX2;
						nxt.accum = acc;
					end
					jsu_pkg::MODE_HEX2: begin
						nxt.mode  = jsu_pkg::MODE_HEX3;
						nxt.accum = acc;
					end
					jsu_pkg::MODE_HEX3: begin
						nxt.mode  = jsu_pkg::MODE_HEX4;
						nxt.accum = acc;
					end
					default: begin
						// Last digit: emit, hold or pair the code point
						nxt.mode  = jsu_pkg::MODE_PLAIN;
						nxt.accum = '0;
						if (acc < jsu_pkg::SURR_FIRST || acc > jsu_pkg::SURR_LAST) begin
							res = jsu_pkg::utf8_encode({5'b0, acc});
						end else if (!cur.held_valid) begin
							nxt.held       = acc;
							nxt.held_valid = 1'b1;
						end else if (new_first == held_first) begin
							res      = jsu_pkg::utf8_encode(jsu_pkg::CP_REPLACE);
							nxt.held = acc;
						end else begin
							nxt.held       = '0;
							nxt.held_valid = 1'b0;
							res = jsu_pkg::utf8_encode(jsu_pkg::CP_PLANE1 +
								{1'b0, hi_half[9:0], lo_half[9:0]});
						end
					end
				endcase
			end
		end else begin
			nxt.mode = jsu_pkg::MODE_PLAIN;
			if (c == jsu_pkg::CHAR_BSLASH) begin
				nxt.mode = jsu_pkg::MODE_ESC;
			end else begin
				res.ent[0] = jsu_pkg::mk_byte(c);
				res.cnt    = jsu_pkg::CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire
